// ===== src/windowed_packet_match_join_defines.svh =====
// ----------------------------------------------------------------------------
// windowed_packet_match_join_defines.svh
// Assertion macros shared by the packet match join RTL.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_PACKET_MATCH_JOIN_DEFINES_SVH
`define WINDOWED_PACKET_MATCH_JOIN_DEFINES_SVH

// clocked check, masked while reset is held
`define WPMJ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check that also holds through reset
`define WPMJ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/wpmj_pkg.sv =====
// ----------------------------------------------------------------------------
// wpmj_pkg
// Types and constants of the windowed packet match join.
// ----------------------------------------------------------------------------
package wpmj_pkg;

  localparam int TABLE_DEPTH_DEF = 65536;
  localparam int CNT_W           = 17;
  localparam int SUM_W           = 48;

  localparam logic [63:0]    FILTER_HASH = 64'hFEED_CAFE_DEAD_BEEF;
  localparam logic [31:0]    WINDOW_RST  = 32'd1_000_000;
  localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};

  // configuration register indexes
  localparam logic [2:0] CFG_REF_START   = 3'd0;
  localparam logic [2:0] CFG_REF_END     = 3'd1;
  localparam logic [2:0] CFG_PROBE_START = 3'd2;
  localparam logic [2:0] CFG_ENTRY_COUNT = 3'd3;
  localparam logic [2:0] CFG_WINDOW      = 3'd4;
  localparam logic [2:0] CFG_MATCH_TYPE  = 3'd5;

  // result codes
  localparam logic [1:0] RC_MATCHED   = 2'd0;
  localparam logic [1:0] RC_UNMATCHED = 2'd1;
  localparam logic [1:0] RC_BEFORE    = 2'd2;
  localparam logic [1:0] RC_AFTER     = 2'd3;

  // input command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PROBE = 1'b1;

  typedef struct packed {
    logic [63:0] ref_time;
    logic [63:0] ref_hash;
    logic [7:0]  ref_type;
  } ref_entry_t;

  typedef struct packed {
    logic        cmd;
    logic [15:0] entry_index;
    logic [63:0] record_time;
    logic [63:0] record_hash;
    logic [7:0]  record_type;
    logic [15:0] dropped_count;
  } in_req_t;

  typedef struct packed {
    logic [1:0]         result_code;
    logic [63:0]        arrival_time;
    logic signed [63:0] latency;
    logic signed [63:0] gap;
    logic [31:0]        unmatched_run;
    logic [15:0]        back_steps;
    logic [15:0]        fwd_step_cnt;
    logic [SUM_W-1:0]   lost_total;
    logic [SUM_W-1:0]   back_total;
    logic [SUM_W-1:0]   fwd_total;
  } out_rsp_t;

endpackage

// ===== src/wpmj_mem.sv =====
// ----------------------------------------------------------------------------
// wpmj_mem
// Reference record table: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module wpmj_mem
  import wpmj_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int AW          = $clog2(TABLE_DEPTH)
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  ref_entry_t      wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output ref_entry_t      rd_data
);

  ref_entry_t mem [TABLE_DEPTH];
  ref_entry_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered output
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/wpmj_guess.sv =====
// ----------------------------------------------------------------------------
// wpmj_guess
// Initial cursor estimate floor(count * elapsed / duration), saturated to lim.
// Shift-add multiply then restoring divide.
// ----------------------------------------------------------------------------
module wpmj_guess
  import wpmj_pkg::*;
#(
  parameter int AW = $clog2(TABLE_DEPTH_DEF)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CNT_W-1:0] count,
  input  logic [63:0]      elapsed,
  input  logic [63:0]      duration,
  input  logic [AW-1:0]    lim,
  output logic             done,
  output logic [AW-1:0]    guess
);

  localparam int PW = CNT_W + 64;

  typedef enum logic [2:0] {
    G_IDLE = 3'b001,
    G_MUL  = 3'b010,
    G_DIV  = 3'b100
  } g_state_t;

  g_state_t         state_r, state_nxt;
  logic [6:0]       cnt_r, cnt_nxt;
  logic [CNT_W-1:0] cval_r, cval_nxt;
  logic [63:0]      e_r, e_nxt;
  logic [63:0]      d_r, d_nxt;
  logic [PW-1:0]    prod_r, prod_nxt;
  logic [PW-1:0]    q_r, q_nxt;
  logic [63:0]      rem_r, rem_nxt;
  logic [AW-1:0]    lim_r, lim_nxt;
  logic [AW-1:0]    guess_r, guess_nxt;
  logic             done_r, done_nxt;
  logic [64:0]      rem_sh;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cval_nxt  = cval_r;
    e_nxt     = e_r;
    d_nxt     = d_r;
    prod_nxt  = prod_r;
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    lim_nxt   = lim_r;
    guess_nxt = guess_r;
    done_nxt  = 1'b0;
    rem_sh    = {rem_r, prod_r[PW-1]};
    unique case (state_r)
      G_IDLE: begin
        if (start) begin
          cval_nxt  = count;
          e_nxt     = elapsed;
          d_nxt     = duration;
          lim_nxt   = lim;
          prod_nxt  = '0;
          cnt_nxt   = 7'(CNT_W - 1);
          state_nxt = G_MUL;
        end
      end
      // one multiplier bit per cycle, MSB first
      G_MUL: begin
        prod_nxt = {prod_r[PW-2:0], 1'b0} + (cval_r[CNT_W-1] ? PW'(e_r) : '0);
        cval_nxt = {cval_r[CNT_W-2:0], 1'b0};
        cnt_nxt  = cnt_r - 7'd1;
        if (cnt_r == '0) begin
          cnt_nxt   = 7'(PW - 1);
          rem_nxt   = '0;
          q_nxt     = '0;
          state_nxt = G_DIV;
        end
      end
      // one quotient bit per cycle
      G_DIV: begin
        prod_nxt = {prod_r[PW-2:0], 1'b0};
        if (rem_sh >= {1'b0, d_r}) begin
          rem_nxt = 64'(rem_sh - {1'b0, d_r});
          q_nxt   = {q_r[PW-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[63:0];
          q_nxt   = {q_r[PW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == '0) begin
          guess_nxt = (q_nxt > PW'(lim_r)) ? lim_r : AW'(q_nxt);
          done_nxt  = 1'b1;
          state_nxt = G_IDLE;
        end
      end
      default: state_nxt = G_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cval_r  <= cval_nxt;
    e_r     <= e_nxt;
    d_r     <= d_nxt;
    prod_r  <= prod_nxt;
    q_r     <= q_nxt;
    rem_r   <= rem_nxt;
    lim_r   <= lim_nxt;
    guess_r <= guess_nxt;
  end

  assign done  = done_r;
  assign guess = guess_r;

endmodule

// ===== src/windowed_packet_match_join.sv =====
// ----------------------------------------------------------------------------
// windowed_packet_match_join
// Reference table join: loads fill the table, probes search it for a match.
// ----------------------------------------------------------------------------
// A load request writes one table entry, when its index is in range, and gives
// no result. A probe's search reads one table entry per cycle from the single
// read port of the table memory, plus one extra read for the gap on a match at
// a nonzero slot. The first probe after reset also runs the cursor estimate in
// the shift-add multiplier and bit-serial divider, unless its operands let the
// cursor start at zero. A finished result waits in the output register while
// loads keep flowing; another probe stalls at its end until that result is
// taken. The table is not cleared at reset.
module windowed_packet_match_join
  import wpmj_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_req_t     in_req,
  output logic        out_valid,
  input  logic        out_stall,
  output out_rsp_t    out_rsp,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

`include "windowed_packet_match_join_defines.svh"

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = ((AW > CNT_W) ? AW : CNT_W) + 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_GUESS = 6'b000010,
    S_CLASS = 6'b000100,
    S_EVAL  = 6'b001000,
    S_GAP   = 6'b010000,
    S_DONE  = 6'b100000
  } s_state_t;

  // configuration
  logic [63:0]      ref_start_r, ref_end_r, probe_start_r;
  logic [CNT_W-1:0] count_r;
  logic [31:0]      window_r;
  logic [7:0]       mtype_r;

  s_state_t         state_r, state_nxt;
  in_req_t          req_r, req_nxt;
  logic [AW-1:0]    cursor_r, cursor_nxt;
  logic             cursor_ok_r, cursor_ok_nxt;
  logic [31:0]      miss_r, miss_nxt;
  logic [SUM_W-1:0] lost_r, lost_nxt, back_r, back_nxt, fwd_r, fwd_nxt;
  logic [AW-1:0]    start_r, start_nxt, at_r, at_nxt, bw_r, bw_nxt, fw_r, fw_nxt;
  logic [63:0]      lowb_r, lowb_nxt, highb_r, highb_nxt;
  logic [63:0]      bwt_r, bwt_nxt, fwt_r, fwt_nxt;
  logic             going_fwd_r, going_fwd_nxt, first_r, first_nxt;
  logic             mv_back_r, mv_back_nxt, matched_r, matched_nxt;
  logic [1:0]       code_r, code_nxt;
  logic [63:0]      lat_r, lat_nxt, gap_r, gap_nxt, at_time_r, at_time_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_rsp_t         out_r, out_nxt;

  logic             accept;
  logic [CNT_W-1:0] n;
  logic [CW-1:0]    n_cw;
  logic [63:0]      base, dur, elapsed;
  logic             guess_skip;
  logic             g_start, g_done;
  logic [AW-1:0]    g_guess;
  logic [AW-1:0]    n_last;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_raddr;
  ref_entry_t       mem_rdata;
  logic [AW-1:0]    start_c;
  logic [64:0]      high_sum;
  logic [63:0]      d_time, bwt, fwt;
  logic             in_win, hit, can_back, can_fwd;
  logic [AW-1:0]    bs, fs;
  logic [SUM_W:0]   back_add, fwd_add, lost_add;
  logic [31:0]      miss_inc;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  // usable entry count
  assign n      = (CW'(count_r) < CW'(TABLE_DEPTH)) ? count_r : CNT_W'(TABLE_DEPTH);
  assign n_cw   = CW'(n);
  assign n_last = AW'(n - CNT_W'(1));

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_start_r   <= '0;
      ref_end_r     <= '0;
      probe_start_r <= '0;
      count_r       <= '0;
      window_r      <= WINDOW_RST;
      mtype_r       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REF_START:   ref_start_r   <= cfg_wdata;
        CFG_REF_END:     ref_end_r     <= cfg_wdata;
        CFG_PROBE_START: probe_start_r <= cfg_wdata;
        CFG_ENTRY_COUNT: count_r       <= cfg_wdata[CNT_W-1:0];
        CFG_WINDOW:      window_r      <= cfg_wdata[31:0];
        CFG_MATCH_TYPE:  mtype_r       <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // cursor estimate operands
  always_comb begin
    if (ref_start_r <= probe_start_r) begin
      base = probe_start_r;
    end else begin
      base = ref_start_r;
    end
    dur        = ref_end_r - base;
    elapsed    = in_req.record_time - base;
    guess_skip = (n == '0) || (elapsed == '0) || elapsed[63] || (dur == '0);
  end

  assign g_start = accept && (in_req.cmd == CMD_PROBE) && !cursor_ok_r && !guess_skip;

  wpmj_guess #(.AW(AW)) u_guess (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (g_start),
    .count    (count_r),
    .elapsed  (elapsed),
    .duration (dur),
    .lim      (n_last),
    .done     (g_done),
    .guess    (g_guess)
  );

  // table writes from load requests
  assign mem_we = accept && (in_req.cmd == CMD_LOAD) &&
                  (32'(in_req.entry_index) < 32'(TABLE_DEPTH));

  wpmj_mem #(.TABLE_DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (AW'(in_req.entry_index)),
    .wr_data ('{ref_time: in_req.record_time, ref_hash: in_req.record_hash,
                ref_type: in_req.record_type}),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // search datapath terms
  always_comb begin
    start_c  = (CW'(cursor_r) < n_cw) ? cursor_r : n_last;
    high_sum = {1'b0, req_r.record_time} + 65'(window_r);
    d_time   = mem_rdata.ref_time;
    bwt      = (first_r || mv_back_r) ? d_time : bwt_r;
    fwt      = (first_r || !mv_back_r) ? d_time : fwt_r;
    in_win   = (d_time > lowb_r) && (d_time < highb_r);
    hit      = (req_r.record_type == mtype_r) && (mem_rdata.ref_type == mtype_r) &&
               (mem_rdata.ref_hash == req_r.record_hash);
    can_back = (bw_r != '0) && (bwt > lowb_r);
    can_fwd  = ((CW'(fw_r) + CW'(1)) < n_cw) && (fwt < highb_r);
    bs       = start_r - bw_r;
    fs       = fw_r - start_r;
    back_add = {1'b0, back_r} + (SUM_W + 1)'(bs);
    fwd_add  = {1'b0, fwd_r} + (SUM_W + 1)'(fs);
    lost_add = {1'b0, lost_r} + (SUM_W + 1)'(req_r.dropped_count);
    miss_inc = (miss_r == '1) ? miss_r : miss_r + 32'd1;
  end

  // probe sequencer
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    cursor_nxt    = cursor_r;
    cursor_ok_nxt = cursor_ok_r;
    miss_nxt      = miss_r;
    lost_nxt      = lost_r;
    back_nxt      = back_r;
    fwd_nxt       = fwd_r;
    start_nxt     = start_r;
    at_nxt        = at_r;
    bw_nxt        = bw_r;
    fw_nxt        = fw_r;
    lowb_nxt      = lowb_r;
    highb_nxt     = highb_r;
    bwt_nxt       = bwt_r;
    fwt_nxt       = fwt_r;
    going_fwd_nxt = going_fwd_r;
    first_nxt     = first_r;
    mv_back_nxt   = mv_back_r;
    matched_nxt   = matched_r;
    code_nxt      = code_r;
    lat_nxt       = lat_r;
    gap_nxt       = gap_r;
    at_time_nxt   = at_time_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_re        = 1'b0;
    mem_raddr     = at_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_req.cmd == CMD_PROBE)) begin
          req_nxt = in_req;
          if (cursor_ok_r) begin
            state_nxt = S_CLASS;
          end else if (guess_skip) begin
            cursor_nxt    = '0;
            cursor_ok_nxt = 1'b1;
            state_nxt     = S_CLASS;
          end else begin
            state_nxt = S_GUESS;
          end
        end
      end
      S_GUESS: begin
        if (g_done) begin
          cursor_nxt    = g_guess;
          cursor_ok_nxt = 1'b1;
          state_nxt     = S_CLASS;
        end
      end
      // classify; unless out of range, filtered or the table is empty, set up the window and issue the first read
      S_CLASS: begin
        matched_nxt = 1'b0;
        lat_nxt     = '0;
        gap_nxt     = '0;
        start_nxt   = '0;
        bw_nxt      = '0;
        fw_nxt      = '0;
        state_nxt   = S_DONE;
        if (req_r.record_time < ref_start_r) begin
          code_nxt = RC_BEFORE;
        end else if (req_r.record_time > ref_end_r) begin
          code_nxt = RC_AFTER;
        end else begin
          code_nxt = RC_UNMATCHED;
          if ((req_r.record_hash != FILTER_HASH) && (n != '0)) begin
            lowb_nxt      = (req_r.record_time >= 64'(window_r)) ?
                            req_r.record_time - 64'(window_r) : '0;
            highb_nxt     = high_sum[64] ? '1 : high_sum[63:0];
            start_nxt     = start_c;
            at_nxt        = start_c;
            bw_nxt        = start_c;
            fw_nxt        = start_c;
            going_fwd_nxt = 1'b1;
            first_nxt     = 1'b1;
            mv_back_nxt   = 1'b0;
            mem_re        = 1'b1;
            mem_raddr     = start_c;
            state_nxt     = S_EVAL;
          end
        end
      end
      // one visited entry per cycle
      S_EVAL: begin
        bwt_nxt   = bwt;
        fwt_nxt   = fwt;
        first_nxt = 1'b0;
        if (!in_win) begin
          state_nxt = S_DONE;
        end else if (hit) begin
          matched_nxt = 1'b1;
          cursor_nxt  = at_r;
          lat_nxt     = req_r.record_time - d_time;
          at_time_nxt = d_time;
          if (at_r != '0) begin
            mem_re    = 1'b1;
            mem_raddr = at_r - AW'(1);
            state_nxt = S_GAP;
          end else begin
            state_nxt = S_DONE;
          end
        end else if ((going_fwd_r && can_back) || (!going_fwd_r && !can_fwd && can_back)) begin
          going_fwd_nxt = 1'b0;
          mv_back_nxt   = 1'b1;
          bw_nxt        = bw_r - AW'(1);
          at_nxt        = bw_r - AW'(1);
          mem_re        = 1'b1;
          mem_raddr     = bw_r - AW'(1);
        end else if (can_fwd) begin
          going_fwd_nxt = 1'b1;
          mv_back_nxt   = 1'b0;
          fw_nxt        = fw_r + AW'(1);
          at_nxt        = fw_r + AW'(1);
          mem_re        = 1'b1;
          mem_raddr     = fw_r + AW'(1);
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_GAP: begin
        gap_nxt   = at_time_r - d_time;
        state_nxt = S_DONE;
      end
      // update totals and present the result
      S_DONE: begin
        if (!(out_valid_r && out_stall)) begin
          back_nxt = back_add[SUM_W] ? SUM_MAX : back_add[SUM_W-1:0];
          fwd_nxt  = fwd_add[SUM_W] ? SUM_MAX : fwd_add[SUM_W-1:0];
          lost_nxt = lost_add[SUM_W] ? SUM_MAX : lost_add[SUM_W-1:0];
          miss_nxt = matched_r ? '0 : miss_inc;
          out_nxt.result_code   = matched_r ? RC_MATCHED : code_r;
          out_nxt.arrival_time  = req_r.record_time;
          out_nxt.latency       = lat_r;
          out_nxt.gap           = gap_r;
          out_nxt.unmatched_run = matched_r ? miss_r : miss_inc;
          out_nxt.back_steps    = 16'(bs);
          out_nxt.fwd_step_cnt  = 16'(fs);
          out_nxt.lost_total    = lost_nxt;
          out_nxt.back_total    = back_nxt;
          out_nxt.fwd_total     = fwd_nxt;
          out_valid_nxt         = 1'b1;
          state_nxt             = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cursor_r    <= '0;
      cursor_ok_r <= 1'b0;
      miss_r      <= '0;
      lost_r      <= '0;
      back_r      <= '0;
      fwd_r       <= '0;
      out_valid_r <= 1'b0;
      start_r     <= '0;
      at_r        <= '0;
      bw_r        <= '0;
      fw_r        <= '0;
      going_fwd_r <= 1'b1;
      first_r     <= 1'b0;
      mv_back_r   <= 1'b0;
      matched_r   <= 1'b0;
      code_r      <= RC_UNMATCHED;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      cursor_ok_r <= cursor_ok_nxt;
      miss_r      <= miss_nxt;
      lost_r      <= lost_nxt;
      back_r      <= back_nxt;
      fwd_r       <= fwd_nxt;
      out_valid_r <= out_valid_nxt;
      start_r     <= start_nxt;
      at_r        <= at_nxt;
      bw_r        <= bw_nxt;
      fw_r        <= fw_nxt;
      going_fwd_r <= going_fwd_nxt;
      first_r     <= first_nxt;
      mv_back_r   <= mv_back_nxt;
      matched_r   <= matched_nxt;
      code_r      <= code_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    lowb_r    <= lowb_nxt;
    highb_r   <= highb_nxt;
    bwt_r     <= bwt_nxt;
    fwt_r     <= fwt_nxt;
    lat_r     <= lat_nxt;
    gap_r     <= gap_nxt;
    at_time_r <= at_time_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

  // checks
  `WPMJ_ASSERT(a_wr_idle, mem_we |-> (state_r == S_IDLE), "table write outside idle")
  `WPMJ_ASSERT(a_walk_order, (state_r == S_EVAL) |-> ((bw_r <= at_r) && (at_r <= fw_r)), "search indexes out of order")
  `WPMJ_ASSERT(a_fwd_bound, (state_r == S_EVAL) |-> (CW'(fw_r) < n_cw), "forward index beyond count")
  `WPMJ_ASSERT(a_done_emit, ((state_r == S_DONE) && !(out_valid_r && out_stall)) |=> out_valid_r, "finished probe gave no result")

endmodule
